### rtl/core/alcm_pkg.sv
// alcm_pkg: shared constants, row record and sequencer states for the
// average-linkage cluster merge block; no dependencies
`default_nettype none
package alcm_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int VAL_W     = 16;
  localparam int NODE_W    = 7;
  localparam int SIZE_W    = 7;
  localparam int MAT_AW    = 2 * IDX_W;
  localparam int MAT_DEPTH = MAX_ITEMS * MAX_ITEMS;
  localparam int PROD_W    = VAL_W + SIZE_W;
  localparam int NUM_W     = PROD_W - 1;
  localparam int DCNT_W    = $clog2(NUM_W + 1);
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct packed {
    logic                    has_best;
    logic signed [VAL_W-1:0] best_val;
    logic [IDX_W-1:0]        best_idx;
    logic [NODE_W-1:0]       owner;
    logic [SIZE_W-1:0]       size;
  } row_ent_t;

  localparam int ROW_W = $bits(row_ent_t);

  typedef enum logic [4:0] {
    S_IDLE,
    S_WR2,
    S_COPY,
    S_INIT_ROW,
    S_SCAN,
    S_SCAN_WR,
    S_SEL_START,
    S_SEL,
    S_SEL_CHK,
    S_KEEP_GOT,
    S_AVG_CHK,
    S_AVG_RA,
    S_AVG_RB,
    S_AVG_SUM,
    S_AVG_DIV,
    S_AVG_W1,
    S_AVG_W2,
    S_RES_RD,
    S_RES_GOT
  } state_t;

endpackage
`default_nettype wire

### rtl/core/alcm_ram.sv
// alcm_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module alcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/alcm_div.sv
// alcm_div: restoring unsigned divider, one quotient bit per cycle
// depends on alcm_pkg
`default_nettype none
module alcm_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [alcm_pkg::NUM_W-1:0]   num,
  input  wire logic [alcm_pkg::SIZE_W-1:0]  den,
  output logic                              done,
  output logic      [alcm_pkg::NUM_W-1:0]   quo
);

  logic                             run;
  logic [alcm_pkg::DCNT_W-1:0]      cnt;
  logic [alcm_pkg::SIZE_W-1:0]      rem;
  logic [alcm_pkg::SIZE_W:0]        trial;
  logic                             fits;

  assign trial = {rem, quo[alcm_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= alcm_pkg::DCNT_W'(alcm_pkg::NUM_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == alcm_pkg::DCNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (run) begin
      rem <= fits ? alcm_pkg::SIZE_W'(trial - {1'b0, den}) : trial[alcm_pkg::SIZE_W-1:0];
      quo <= {quo[alcm_pkg::NUM_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

### rtl/core/average_linkage_cluster_merge.sv
// average_linkage_cluster_merge: upgma clustering over a loaded similarity matrix
// depends on alcm_pkg, alcm_ram, alcm_div
// a matrix write beat writes both mirror entries, the second in S_WR2 while busy is high
// a start beat copies the loaded matrix into the working copy, scans every row, then per
// merge runs a selection sweep over all rows, an averaging pass per active column through
// the divider and one rescan for each affected row; busy stays high throughout
// one result beat per merge, issued from the merge check after the next selection sweep
// reset: synchronous, clears control state and sets items_used to 64; matrix undefined
`default_nettype none
module average_linkage_cluster_merge (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               cmd,
  input  wire logic [alcm_pkg::IDX_W-1:0]         row,
  input  wire logic [alcm_pkg::IDX_W-1:0]         col,
  input  wire logic signed [alcm_pkg::VAL_W-1:0]  value,
  input  wire logic                               cfg_wr_en,
  input  wire logic [alcm_pkg::CNT_W-1:0]         cfg_wr_data,
  output logic                                    done,
  output logic [alcm_pkg::NODE_W-1:0]             node_id,
  output logic [alcm_pkg::NODE_W-1:0]             first_child,
  output logic [alcm_pkg::NODE_W-1:0]             second_child,
  output logic signed [alcm_pkg::VAL_W-1:0]       height,
  output logic                                    last
);

  localparam int IW = alcm_pkg::IDX_W;
  localparam int CW = alcm_pkg::CNT_W;
  localparam int VW = alcm_pkg::VAL_W;

  alcm_pkg::state_t state, state_next;

  // config
  logic [CW-1:0] items_used;
  logic [CW-1:0] n_items;

  // loaded beat
  logic [IW-1:0]        wr_row, wr_col;
  logic signed [VW-1:0] wr_val;

  // copy sweep
  logic [alcm_pkg::MAT_AW:0]   cp_k;
  logic                        cp_v;
  logic [alcm_pkg::MAT_AW-1:0] cp_a;

  // row scan engine
  logic [CW-1:0]         r_cnt;
  logic [IW-1:0]         scan_r;
  logic [CW-1:0]         scan_m;
  logic                  scan_pv;
  logic [IW-1:0]         scan_pm;
  logic                  scan_has;
  logic signed [VW-1:0]  scan_val;
  logic [IW-1:0]         scan_idx;
  logic [alcm_pkg::NODE_W-1:0] scan_owner;
  logic [alcm_pkg::SIZE_W-1:0] scan_size;
  logic                  scan_init;
  logic signed [VW-1:0]  global_min;

  // selection
  logic [CW-1:0]         sel_i;
  logic                  sel_pv;
  logic [IW-1:0]         sel_pr;
  logic                  found;
  logic [IW-1:0]         sel_row, keep_row;
  logic signed [VW-1:0]  sel_height;
  logic [alcm_pkg::NODE_W-1:0] sel_owner;
  logic [alcm_pkg::SIZE_W-1:0] sel_size;
  logic [CW-1:0]         merge_count;
  logic                  go_on;
  logic [alcm_pkg::NODE_W-1:0] node;

  // averaging
  logic [alcm_pkg::SIZE_W-1:0] na, nb;
  logic [CW-1:0]         p_cnt;
  logic [IW-1:0]         p_idx;
  logic signed [VW-1:0]  a_val;
  logic signed [alcm_pkg::PROD_W-1:0] prod_a, prod_b, num_sum;
  logic                  neg;
  logic signed [VW-1:0]  avg_val;

  logic [alcm_pkg::MAX_ITEMS-1:0] active;

  // pending result, shown once the next round or the end is known
  logic                  pend_v;
  logic [alcm_pkg::NODE_W-1:0] pend_node, pend_first, pend_second;
  logic signed [VW-1:0]  pend_height;

  // memory ports
  logic                         sim_we;
  logic [alcm_pkg::MAT_AW-1:0]  sim_wa, sim_ra;
  logic [VW-1:0]                sim_wd, sim_rd;
  logic                         work_we;
  logic [alcm_pkg::MAT_AW-1:0]  work_wa, work_ra;
  logic [VW-1:0]                work_wd, work_rd;
  logic                         row_we;
  logic [IW-1:0]                row_wa, row_ra;
  alcm_pkg::row_ent_t           row_wd, row_rd;
  logic [alcm_pkg::ROW_W-1:0]   row_rdata;

  logic                         div_start, div_done;
  logic [alcm_pkg::NUM_W-1:0]   div_num, div_quo;
  logic [alcm_pkg::SIZE_W-1:0]  div_den;

  logic                  res_hit;
  logic                  res_redirect;
  logic signed [VW-1:0]  work_rs;

  assign row_rd  = alcm_pkg::row_ent_t'(row_rdata);
  assign work_rs = $signed(work_rd);
  assign p_idx   = p_cnt[IW-1:0];
  assign busy    = (state != alcm_pkg::S_IDLE);
  assign node    = alcm_pkg::NODE_W'(n_items + merge_count);
  assign div_den = na + nb;
  assign num_sum = prod_a + prod_b;

  // items_used clamped to the supported range
  always_comb begin
    if (items_used < CW'(2)) begin
      n_items = CW'(2);
    end else if (items_used > CW'(alcm_pkg::MAX_ITEMS)) begin
      n_items = CW'(alcm_pkg::MAX_ITEMS);
    end else begin
      n_items = items_used;
    end
  end

  // another merge is possible with the selected pair
  assign go_on = (({1'b0, merge_count} + (CW+1)'(1)) < {1'b0, n_items}) && found &&
                 ({1'b0, keep_row} < n_items) && (keep_row != sel_row) && active[keep_row];

  // row needs attention after a merge
  assign res_hit = active[p_idx] && (row_rd.best_idx == keep_row ||
                                     row_rd.best_idx == sel_row);
  // global-minimum shortcut: partner redirected, value kept
  assign res_redirect = row_rd.has_best && (row_rd.best_val == global_min) &&
                        (p_idx != keep_row);

  // ---------------------------------------------------------------- memories
  alcm_ram #(.WIDTH(VW), .DEPTH(alcm_pkg::MAT_DEPTH)) u_sim_ram (
    .clk(clk), .we(sim_we), .waddr(sim_wa), .wdata(sim_wd), .raddr(sim_ra), .rdata(sim_rd)
  );

  // working copy of the matrix, averaged in place
  alcm_ram #(.WIDTH(VW), .DEPTH(alcm_pkg::MAT_DEPTH)) u_work_ram (
    .clk(clk), .we(work_we), .waddr(work_wa), .wdata(work_wd), .raddr(work_ra),
    .rdata(work_rd)
  );

  // per-row best partner, owner node and cluster size
  alcm_ram #(.WIDTH(alcm_pkg::ROW_W), .DEPTH(alcm_pkg::MAX_ITEMS)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_wa), .wdata(row_wd), .raddr(row_ra),
    .rdata(row_rdata)
  );

  alcm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      alcm_pkg::S_IDLE: begin
        if (start) begin
          state_next = cmd ? alcm_pkg::S_COPY : alcm_pkg::S_WR2;
        end
      end
      alcm_pkg::S_WR2:  state_next = alcm_pkg::S_IDLE;
      alcm_pkg::S_COPY: begin
        if (cp_k[alcm_pkg::MAT_AW] && !cp_v) begin
          state_next = alcm_pkg::S_INIT_ROW;
        end
      end
      alcm_pkg::S_INIT_ROW: begin
        state_next = (r_cnt >= n_items) ? alcm_pkg::S_SEL_START : alcm_pkg::S_SCAN;
      end
      alcm_pkg::S_SCAN: begin
        if (scan_m >= n_items && !scan_pv) begin
          state_next = alcm_pkg::S_SCAN_WR;
        end
      end
      alcm_pkg::S_SCAN_WR: begin
        state_next = scan_init ? alcm_pkg::S_INIT_ROW : alcm_pkg::S_RES_RD;
      end
      alcm_pkg::S_SEL_START: state_next = alcm_pkg::S_SEL;
      alcm_pkg::S_SEL: begin
        if (sel_i >= n_items && !sel_pv) begin
          state_next = alcm_pkg::S_SEL_CHK;
        end
      end
      alcm_pkg::S_SEL_CHK: begin
        state_next = go_on ? alcm_pkg::S_KEEP_GOT : alcm_pkg::S_IDLE;
      end
      alcm_pkg::S_KEEP_GOT: state_next = alcm_pkg::S_AVG_CHK;
      alcm_pkg::S_AVG_CHK: begin
        if (p_cnt >= n_items) begin
          state_next = alcm_pkg::S_RES_RD;
        end else if (p_idx != keep_row && active[p_idx]) begin
          state_next = alcm_pkg::S_AVG_RA;
        end
      end
      alcm_pkg::S_AVG_RA:  state_next = alcm_pkg::S_AVG_RB;
      alcm_pkg::S_AVG_RB:  state_next = alcm_pkg::S_AVG_SUM;
      alcm_pkg::S_AVG_SUM: state_next = alcm_pkg::S_AVG_DIV;
      alcm_pkg::S_AVG_DIV: begin
        if (div_done) begin
          state_next = alcm_pkg::S_AVG_W1;
        end
      end
      alcm_pkg::S_AVG_W1: state_next = alcm_pkg::S_AVG_W2;
      alcm_pkg::S_AVG_W2: state_next = alcm_pkg::S_AVG_CHK;
      alcm_pkg::S_RES_RD: begin
        state_next = (p_cnt >= n_items) ? alcm_pkg::S_SEL_START : alcm_pkg::S_RES_GOT;
      end
      alcm_pkg::S_RES_GOT: begin
        state_next = (res_hit && !res_redirect) ? alcm_pkg::S_SCAN : alcm_pkg::S_RES_RD;
      end
      default: state_next = alcm_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- memory control
  always_comb begin
    sim_we    = 1'b0;
    sim_wa    = {row, col};
    sim_wd    = value;
    sim_ra    = cp_k[alcm_pkg::MAT_AW-1:0];
    work_we   = 1'b0;
    work_wa   = cp_a;
    work_wd   = sim_rd;
    work_ra   = {scan_r, scan_m[IW-1:0]};
    row_we    = 1'b0;
    row_wa    = scan_r;
    row_wd    = '{has_best: scan_has, best_val: scan_val, best_idx: scan_idx,
                  owner: scan_owner, size: scan_size};
    row_ra    = sel_i[IW-1:0];
    div_start = 1'b0;
    div_num   = num_sum[alcm_pkg::PROD_W-1] ? alcm_pkg::NUM_W'(-num_sum)
                                            : alcm_pkg::NUM_W'(num_sum);
    unique case (state)
      alcm_pkg::S_IDLE: begin
        sim_we = start && !cmd;
      end
      alcm_pkg::S_WR2: begin
        sim_we = 1'b1;
        sim_wa = {wr_col, wr_row};
        sim_wd = wr_val;
      end
      alcm_pkg::S_COPY: begin
        work_we = cp_v;
      end
      alcm_pkg::S_SCAN_WR: begin
        row_we = 1'b1;
      end
      alcm_pkg::S_SEL_CHK: begin
        row_ra = keep_row;
      end
      alcm_pkg::S_KEEP_GOT: begin
        row_we = 1'b1;
        row_wa = keep_row;
        row_wd = '{has_best: row_rd.has_best, best_val: row_rd.best_val, best_idx: keep_row,
                   owner: node, size: row_rd.size + sel_size};
      end
      alcm_pkg::S_AVG_CHK: begin
        work_ra = {keep_row, p_idx};
      end
      alcm_pkg::S_AVG_RA: begin
        work_ra = {sel_row, p_idx};
      end
      alcm_pkg::S_AVG_SUM: begin
        div_start = 1'b1;
      end
      alcm_pkg::S_AVG_W1: begin
        work_we = 1'b1;
        work_wa = {keep_row, p_idx};
        work_wd = avg_val;
      end
      alcm_pkg::S_AVG_W2: begin
        work_we = 1'b1;
        work_wa = {p_idx, keep_row};
        work_wd = avg_val;
      end
      alcm_pkg::S_RES_RD: begin
        row_ra = p_idx;
      end
      alcm_pkg::S_RES_GOT: begin
        row_we = res_hit && res_redirect;
        row_wa = p_idx;
        row_wd = '{has_best: row_rd.has_best, best_val: row_rd.best_val, best_idx: keep_row,
                   owner: row_rd.owner, size: row_rd.size};
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= alcm_pkg::S_IDLE;
      items_used  <= CW'(alcm_pkg::MAX_ITEMS);
      active      <= '0;
      pend_v      <= 1'b0;
      done        <= 1'b0;
      cp_v        <= 1'b0;
      scan_pv     <= 1'b0;
      sel_pv      <= 1'b0;
      found       <= 1'b0;
      merge_count <= '0;
      global_min  <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_wr_en) begin
        items_used <= cfg_wr_data;
      end
      case (state)
        alcm_pkg::S_IDLE: begin
          if (start && cmd) begin
            cp_v        <= 1'b0;
            global_min  <= alcm_pkg::VAL_MAX;
            merge_count <= '0;
            pend_v      <= 1'b0;
            for (int i = 0; i < alcm_pkg::MAX_ITEMS; i++) begin
              active[i] <= (CW'(i) < n_items);
            end
          end
        end
        alcm_pkg::S_COPY: begin
          cp_v <= !cp_k[alcm_pkg::MAT_AW];
        end
        alcm_pkg::S_INIT_ROW: begin
          scan_pv <= 1'b0;
        end
        alcm_pkg::S_SCAN: begin
          scan_pv <= (scan_m < n_items);
          if (scan_pv && scan_init && work_rs < global_min) begin
            global_min <= work_rs;
          end
        end
        alcm_pkg::S_SEL_START: begin
          found  <= 1'b0;
          sel_pv <= 1'b0;
        end
        alcm_pkg::S_SEL: begin
          sel_pv <= (sel_i < n_items);
          if (sel_pv && active[sel_pr] && row_rd.has_best &&
              (!found || row_rd.best_val > sel_height)) begin
            found <= 1'b1;
          end
        end
        alcm_pkg::S_SEL_CHK: begin
          done <= pend_v;
          if (!go_on) begin
            pend_v <= 1'b0;
          end
        end
        alcm_pkg::S_KEEP_GOT: begin
          pend_v          <= 1'b1;
          active[sel_row] <= 1'b0;
        end
        alcm_pkg::S_RES_RD: begin
          if (p_cnt >= n_items) begin
            merge_count <= merge_count + 1'b1;
          end
        end
        alcm_pkg::S_RES_GOT: begin
          scan_pv <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk) begin
    case (state)
      alcm_pkg::S_IDLE: begin
        wr_row <= row;
        wr_col <= col;
        wr_val <= value;
        cp_k   <= '0;
        r_cnt  <= '0;
      end
      alcm_pkg::S_COPY: begin
        cp_a <= cp_k[alcm_pkg::MAT_AW-1:0];
        if (!cp_k[alcm_pkg::MAT_AW]) begin
          cp_k <= cp_k + 1'b1;
        end
      end
      alcm_pkg::S_INIT_ROW: begin
        // leaf row: owner is the row itself, size one
        scan_r     <= r_cnt[IW-1:0];
        scan_m     <= r_cnt + 1'b1;
        scan_has   <= 1'b0;
        scan_idx   <= '0;
        scan_owner <= alcm_pkg::NODE_W'(r_cnt);
        scan_size  <= alcm_pkg::SIZE_W'(1);
        scan_init  <= 1'b1;
      end
      alcm_pkg::S_SCAN: begin
        if (scan_m < n_items) begin
          scan_pm <= scan_m[IW-1:0];
          scan_m  <= scan_m + 1'b1;
        end
        // strict compare keeps the lowest column on ties
        if (scan_pv && active[scan_pm] && (!scan_has || work_rs > scan_val)) begin
          scan_has <= 1'b1;
          scan_val <= work_rs;
          scan_idx <= scan_pm;
        end
      end
      alcm_pkg::S_SCAN_WR: begin
        if (scan_init) begin
          r_cnt <= r_cnt + 1'b1;
        end else begin
          p_cnt <= p_cnt + 1'b1;
        end
      end
      alcm_pkg::S_SEL_START: begin
        sel_i <= '0;
      end
      alcm_pkg::S_SEL: begin
        if (sel_i < n_items) begin
          sel_pr <= sel_i[IW-1:0];
          sel_i  <= sel_i + 1'b1;
        end
        // strict compare keeps the lowest row on ties
        if (sel_pv && active[sel_pr] && row_rd.has_best &&
            (!found || row_rd.best_val > sel_height)) begin
          sel_row    <= sel_pr;
          sel_height <= row_rd.best_val;
          keep_row   <= row_rd.best_idx;
          sel_owner  <= row_rd.owner;
          sel_size   <= row_rd.size;
        end
      end
      alcm_pkg::S_SEL_CHK: begin
        node_id      <= pend_node;
        first_child  <= pend_first;
        second_child <= pend_second;
        height       <= pend_height;
        last         <= !go_on;
      end
      alcm_pkg::S_KEEP_GOT: begin
        pend_node   <= node;
        pend_first  <= sel_owner;
        pend_second <= row_rd.owner;
        pend_height <= sel_height;
        na          <= row_rd.size;
        nb          <= sel_size;
        p_cnt       <= '0;
      end
      alcm_pkg::S_AVG_CHK: begin
        if (p_cnt >= n_items) begin
          p_cnt <= '0;
        end else if (p_idx == keep_row || !active[p_idx]) begin
          p_cnt <= p_cnt + 1'b1;
        end
      end
      alcm_pkg::S_AVG_RA: begin
        a_val <= work_rs;
      end
      alcm_pkg::S_AVG_RB: begin
        prod_a <= alcm_pkg::PROD_W'(a_val) *
                  alcm_pkg::PROD_W'($signed({1'b0, na}));
        prod_b <= alcm_pkg::PROD_W'(work_rs) *
                  alcm_pkg::PROD_W'($signed({1'b0, nb}));
      end
      alcm_pkg::S_AVG_SUM: begin
        neg <= num_sum[alcm_pkg::PROD_W-1];
      end
      alcm_pkg::S_AVG_DIV: begin
        // truncation toward zero: divide magnitude, restore sign
        avg_val <= neg ? -$signed(div_quo[VW-1:0]) : $signed(div_quo[VW-1:0]);
      end
      alcm_pkg::S_AVG_W2: begin
        p_cnt <= p_cnt + 1'b1;
      end
      alcm_pkg::S_RES_GOT: begin
        if (!res_hit || res_redirect) begin
          p_cnt <= p_cnt + 1'b1;
        end else begin
          // rescan keeps owner, size and the old partner if nothing is found
          scan_r     <= p_idx;
          scan_m     <= p_cnt + 1'b1;
          scan_has   <= 1'b0;
          scan_idx   <= row_rd.best_idx;
          scan_owner <= row_rd.owner;
          scan_size  <= row_rd.size;
          scan_init  <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- assertions
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == alcm_pkg::S_AVG_DIV)
    else $error("divider finished outside the averaging wait");

  a_beat_from_check: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == alcm_pkg::S_SEL_CHK)
    else $error("result beat not issued from the merge check");

  a_work_write_phase: assert property (@(posedge clk) disable iff (rst)
    work_we |-> (state == alcm_pkg::S_COPY || state == alcm_pkg::S_AVG_W1 ||
                 state == alcm_pkg::S_AVG_W2))
    else $error("working matrix written outside copy or averaging");

  a_sel_retired: assert property (@(posedge clk) disable iff (rst)
    state == alcm_pkg::S_KEEP_GOT |=> !active[sel_row])
    else $error("merged row still active");

  a_no_sim_write_in_run: assert property (@(posedge clk) disable iff (rst)
    sim_we |-> (state == alcm_pkg::S_IDLE || state == alcm_pkg::S_WR2))
    else $error("loaded matrix written during a run");

endmodule
`default_nettype wire
